FILE: design/sllf_pkg.sv
// shared types, constants and helpers for the stereo ladder lowpass filter
// depends on nothing

package sllf_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF    = 20;
   localparam int WORD_WIDTH       = 32;
   localparam int RES_WIDTH        = 16;
   localparam int CUTOFF_WIDTH     = 17;
   localparam int CSR_ADDR_WIDTH   = 3;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RESONANCE = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ENABLE    = 3'd4;

   // micro-op codes of the ladder sequencer
   typedef enum logic [2:0] {
      OP_ADD,      // a + b
      OP_SUB,      // a - b
      OP_MUL,      // qmul(a, b)
      OP_MULSUB,   // qmul(a, pc) - qmul(b, f), with pc and f from fixed registers
      OP_DIFMUL    // qmul(a, b) - qmul(c, d) by name; the ladder sequencer only advances the step on it
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   // multiplier request between sequencer and serial multiplier
   typedef struct packed {
      logic                    start;
      logic [WORD_WIDTH-1:0]   a;
      logic [WORD_WIDTH-1:0]   b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic [WORD_WIDTH-1:0]   p;
   } mul_rsp_type;

   function automatic logic [WORD_WIDTH-1:0] sat_add(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b,
                                                     input logic                  sub);
      logic [WORD_WIDTH:0] s;
      s = sub ? ({a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b})
              : ({a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b});
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
         sat_add = s[WORD_WIDTH] ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                                 : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      else
         sat_add = s[WORD_WIDTH-1:0];
   endfunction

endpackage

FILE: design/sllf_mul.sv
// bit-serial signed fixed-point multiplier: floor shift by frac bits, 32-bit saturation
// depends on sllf_pkg

module sllf_mul
   import sllf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam int PW = 2 * WORD_WIDTH;
   localparam int CW = $clog2(WORD_WIDTH + 1);

   logic [PW-1:0]         acc_ff, acc_in;
   logic [PW-1:0]         mcand_ff, mcand_in;
   logic [WORD_WIDTH-1:0] mplier_ff, mplier_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [PW-1:0]         shifted;
   logic [PW-1:0]         term;

   // shift-and-add one multiplier bit per cycle; top bit carries negative weight
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      term      = mplier_ff[0] ? mcand_ff : '0;
      if (req.start) begin
         acc_in    = '0;
         mcand_in  = {{WORD_WIDTH{req.a[WORD_WIDTH-1]}}, req.a};
         mplier_in = req.b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CW'(WORD_WIDTH - 1))
            acc_in = acc_ff - term;
         else
            acc_in = acc_ff + term;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WORD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign shifted = $signed(acc_ff) >>> FRAC_BITS;

   always_comb begin
      rsp.done = done_ff;
      if (shifted[PW-1] && !(&shifted[PW-2:WORD_WIDTH-1]))
         rsp.p = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      else if (!shifted[PW-1] && (|shifted[PW-2:WORD_WIDTH-1]))
         rsp.p = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      else
         rsp.p = shifted[WORD_WIDTH-1:0];
   end

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("multiplier done longer than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_in |-> busy_ff) else $error("multiplier done without a run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("multiplier restarted while busy");
`endif

endmodule

FILE: design/sllf_ladder.sv
// one ladder channel: five stage words and a micro-program over its own serial multiplier
// depends on sllf_pkg and sllf_mul

module sllf_ladder
   import sllf_pkg::*;
#(
   parameter int                  FRAC_BITS = FRAC_BITS_DEF,
   parameter logic [WORD_WIDTH-1:0] TUNE    = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] x,
   input  logic [WORD_WIDTH-1:0] fr,
   input  logic [WORD_WIDTH-1:0] res,
   output logic                  done,
   output logic [WORD_WIDTH-1:0] y
);

   localparam logic [WORD_WIDTH-1:0] ONE_Q  = WORD_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic [WORD_WIDTH-1:0] HALF_Q = WORD_WIDTH'(64'd1 << (FRAC_BITS - 1));
   localparam logic [WORD_WIDTH-1:0] POLY_C = WORD_WIDTH'((64'd56 << FRAC_BITS) / 10);
   localparam logic [WORD_WIDTH-1:0] CLIP_C =
      WORD_WIDTH'((64'd166667 << FRAC_BITS) / 1000000);
   localparam int NSTEP = 27;
   localparam int SW    = $clog2(NSTEP + 1);

   // register file: 0..4 stages, then scratch
   localparam int R_S0 = 0, R_S4 = 4, R_Q = 5, R_PC = 6, R_F = 7, R_T = 8, R_U = 9,
                  R_G = 10, R_IN = 11, R_N = 12, R_A = 13, R_X = 14, R_FR = 15,
                  R_RES = 16, R_ONE = 17, R_HALF = 18, R_POLY = 19, R_CLIP = 20,
                  R_TUNE = 21, R_ZERO = 22, NREG = 23;
   localparam int RW = $clog2(NREG);

   typedef struct packed {
      op_type          op;
      logic [RW-1:0]   d;
      logic [RW-1:0]   a;
      logic [RW-1:0]   b;
   } uop_type;

   function automatic uop_type mk(op_type o, int d, int a, int b);
      mk.op = o;
      mk.d  = RW'(d);
      mk.a  = RW'(a);
      mk.b  = RW'(b);
   endfunction

   // OP_DIFMUL is not used by this program; the sequencer only advances the step on it
   function automatic uop_type prog(logic [SW-1:0] i);
      case (i)
         SW'(0):  prog = mk(OP_SUB, R_Q, R_ONE, R_FR);
         SW'(1):  prog = mk(OP_MUL, R_T, R_TUNE, R_FR);
         SW'(2):  prog = mk(OP_MUL, R_T, R_T, R_Q);
         SW'(3):  prog = mk(OP_ADD, R_PC, R_FR, R_T);
         SW'(4):  prog = mk(OP_ADD, R_F, R_PC, R_PC);
         SW'(5):  prog = mk(OP_SUB, R_F, R_F, R_ONE);
         SW'(6):  prog = mk(OP_MUL, R_T, R_POLY, R_Q);
         SW'(7):  prog = mk(OP_MUL, R_T, R_T, R_Q);
         SW'(8):  prog = mk(OP_SUB, R_U, R_ONE, R_Q);
         SW'(9):  prog = mk(OP_ADD, R_U, R_U, R_T);
         SW'(10): prog = mk(OP_MUL, R_T, R_HALF, R_Q);
         SW'(11): prog = mk(OP_MUL, R_T, R_T, R_U);
         SW'(12): prog = mk(OP_ADD, R_T, R_ONE, R_T);
         SW'(13): prog = mk(OP_MUL, R_G, R_RES, R_T);
         SW'(14): prog = mk(OP_MUL, R_T, R_G, R_S4);
         SW'(15): prog = mk(OP_SUB, R_IN, R_X, R_T);
         // four poles: a = (prev_new + s_k-1) , computed with R_A as running new value
         SW'(16): prog = mk(OP_ADD, R_A, R_IN, R_S0);
         SW'(17): prog = mk(OP_MULSUB, 1, R_A, 1);
         SW'(18): prog = mk(OP_MULSUB, 2, R_A, 2);
         SW'(19): prog = mk(OP_MULSUB, 3, R_A, 3);
         SW'(20): prog = mk(OP_MULSUB, R_N, R_A, 4);
         SW'(21): prog = mk(OP_MUL, R_T, R_N, R_N);
         SW'(22): prog = mk(OP_MUL, R_T, R_T, R_N);
         SW'(23): prog = mk(OP_MUL, R_T, R_T, R_CLIP);
         SW'(24): prog = mk(OP_SUB, R_S4, R_N, R_T);
         SW'(25): prog = mk(OP_ADD, R_S0, R_IN, R_ZERO);
         default: prog = mk(OP_ADD, R_ZERO, R_ZERO, R_ZERO);
      endcase
   endfunction

   logic [WORD_WIDTH-1:0] rf_ff [NREG];
   logic [SW-1:0]         pc_ff, pc_in;
   logic                  run_ff, run_in;
   logic [1:0]            ph_ff, ph_in;   // sub-phase of mul and mulsub
   logic [WORD_WIDTH-1:0] hold_ff, hold_in;
   logic                  done_ff, done_in;
   logic                  wr;
   logic [RW-1:0]         wd;
   logic [WORD_WIDTH-1:0] wv;
   mul_req_type           mreq;
   mul_rsp_type           mrsp;
   uop_type               u;
   logic [WORD_WIDTH-1:0] va, vb;

   sllf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   assign u  = prog(pc_ff);
   assign va = rf_ff[u.a];
   assign vb = rf_ff[u.b];

   // mulsub for pole k: ph0 start t = a*pc ; ph1 hold t ; ph2 start t2 = s_k*f ; ph3 write s_k = t - t2,
   // a = s_k_new + s_k_old
   always_comb begin
      pc_in   = pc_ff;
      run_in  = run_ff;
      ph_in   = ph_ff;
      hold_in = hold_ff;
      done_in = 1'b0;
      wr      = 1'b0;
      wd      = u.d;
      wv      = '0;
      mreq    = '{start: 1'b0, a: va, b: vb};
      if (start && !run_ff) begin
         run_in = 1'b1;
         pc_in  = '0;
         ph_in  = '0;
      end else if (run_ff) begin
         unique case (u.op)
            OP_ADD, OP_SUB: begin
               wr    = 1'b1;
               wv    = sat_add(va, vb, u.op == OP_SUB);
               pc_in = pc_ff + 1'b1;
            end
            OP_MUL: begin
               if (ph_ff == 2'd0) begin
                  mreq.start = 1'b1;
                  ph_in      = 2'd1;
               end else if (mrsp.done) begin
                  wr    = 1'b1;
                  wv    = mrsp.p;
                  ph_in = 2'd0;
                  pc_in = pc_ff + 1'b1;
               end
            end
            OP_MULSUB: begin
               case (ph_ff)
                  2'd0: begin
                     mreq = '{start: 1'b1, a: va, b: rf_ff[R_PC]};
                     ph_in = 2'd1;
                  end
                  2'd1: begin
                     if (mrsp.done) begin
                        hold_in = mrsp.p;
                        ph_in   = 2'd2;
                     end
                  end
                  2'd2: begin
                     mreq = '{start: 1'b1, a: vb, b: rf_ff[R_F]};
                     ph_in = 2'd3;
                  end
                  default: begin
                     if (mrsp.done) begin
                        wr    = 1'b1;
                        wv    = sat_add(hold_ff, mrsp.p, 1'b1);
                        ph_in = 2'd0;
                        pc_in = pc_ff + 1'b1;
                     end
                  end
               endcase
            end
            default: pc_in = pc_ff + 1'b1;
         endcase
         if (pc_ff == SW'(NSTEP - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pc_ff   <= '0;
         ph_ff   <= '0;
         done_ff <= 1'b0;
         for (int i = 0; i < NREG; i++)
            rf_ff[i] <= '0;
      end else begin
         run_ff  <= run_in;
         pc_ff   <= pc_in;
         ph_ff   <= ph_in;
         done_ff <= done_in;
         if (start && !run_ff) begin
            rf_ff[R_X]    <= x;
            rf_ff[R_FR]   <= fr;
            rf_ff[R_RES]  <= res;
            rf_ff[R_ONE]  <= ONE_Q;
            rf_ff[R_HALF] <= HALF_Q;
            rf_ff[R_POLY] <= POLY_C;
            rf_ff[R_CLIP] <= CLIP_C;
            rf_ff[R_TUNE] <= TUNE;
            rf_ff[R_ZERO] <= '0;
         end else if (wr) begin
            rf_ff[wd] <= wv;
            // next pole input is new value plus this pole's old value
            if (u.op == OP_MULSUB)
               rf_ff[R_A] <= sat_add(wv, rf_ff[u.b], 1'b0);
         end
      end
      hold_ff <= hold_in;
   end

   assign done = done_ff;
   assign y    = rf_ff[R_S4];

`ifndef ASSERT_OFF
   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("ladder done while still running");
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> pc_ff < SW'(NSTEP)) else $error("ladder program counter out of range");
   a_one_const: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> rf_ff[R_ONE] == ONE_Q) else $error("constant register overwritten");
`endif

endmodule

FILE: design/stereo_ladder_lowpass_filter_core.sv
// top level of the stereo ladder lowpass filter: stream ports, csr port, two ladders
// depends on sllf_pkg, sllf_ladder and sllf_mul

// One word in, one word out. Both channels run in parallel. Each channel runs a 27-step
// micro-program on its own bit-serial 32x32 multiplier. There are 19 products per sample,
// each made by shift-and-add; a pole step holds two products. With bypass the word goes
// from the run state straight to the output state and is not filtered. The result sits in
// an output register, so the next word is taken in the cycle after the previous result
// has been read. No clearing pass after reset.
module stereo_ladder_lowpass_filter_core
   import sllf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // sample_in [SAMPLE_WIDTH-1:0], cutoff above, zero fill
   input  logic [((SAMPLE_WIDTH+CUTOFF_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // left_out lowest, right_out above, zero fill
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int OW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam logic signed [WORD_WIDTH-1:0] SMAX = WORD_WIDTH'((64'd1 << (SAMPLE_WIDTH-1)) - 1);
   localparam logic signed [WORD_WIDTH-1:0] SMIN = -SMAX - 1;
   localparam logic [WORD_WIDTH-1:0] TUNE_L = WORD_WIDTH'((64'd8 << FRAC_BITS) / 10);
   localparam logic [WORD_WIDTH-1:0] TUNE_R = WORD_WIDTH'((64'd4 << FRAC_BITS) / 10);

   state_type state_ff, state_in;
   logic [RES_WIDTH-1:0]    res_ff;
   logic                    en_ff;
   logic [SAMPLE_WIDTH-1:0] samp_ff;
   logic [CUTOFF_WIDTH-1:0] cut_ff;
   logic                    byp_ff;
   logic [SAMPLE_WIDTH-1:0] left_ff, left_in, right_ff, right_in;
   logic                    go;
   logic                    done_l, done_r, got_l_ff, got_r_ff;
   logic [WORD_WIDTH-1:0]   y_l, y_r, x_w, fr_w, res_w;
   logic [CUTOFF_WIDTH-1:0] cut_c;
   logic                    in_acc, out_acc;

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr)
         REG_RESONANCE: csr_prdata = {16'd0, res_ff};
         REG_ENABLE:    csr_prdata = {31'd0, en_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   assign cut_c = (cut_ff > CUTOFF_WIDTH'(65536)) ? CUTOFF_WIDTH'(65536) : cut_ff;
   assign x_w   = WORD_WIDTH'($signed(samp_ff));
   // rescale q1.16 cutoff and q2.14 resonance to the working fraction
   assign fr_w  = WORD_WIDTH'((64'(cut_c) << FRAC_BITS) >> 16);
   assign res_w = WORD_WIDTH'((64'(res_ff) << FRAC_BITS) >> 14);
   assign go    = (state_ff == ST_RUN) && !byp_ff && !got_l_ff && !got_r_ff;

   sllf_ladder #(.FRAC_BITS(FRAC_BITS), .TUNE(TUNE_L)) u_left (
      .clock(clock), .reset(reset), .start(go && state_in == ST_RUN), .x(x_w), .fr(fr_w),
      .res(res_w), .done(done_l), .y(y_l)
   );
   sllf_ladder #(.FRAC_BITS(FRAC_BITS), .TUNE(TUNE_R)) u_right (
      .clock(clock), .reset(reset), .start(go && state_in == ST_RUN), .x(x_w), .fr(fr_w),
      .res(res_w), .done(done_r), .y(y_r)
   );

   function automatic logic [SAMPLE_WIDTH-1:0] sat_s(logic [WORD_WIDTH-1:0] v);
      if ($signed(v) > SMAX)      sat_s = SMAX[SAMPLE_WIDTH-1:0];
      else if ($signed(v) < SMIN) sat_s = SMIN[SAMPLE_WIDTH-1:0];
      else                        sat_s = v[SAMPLE_WIDTH-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_acc) state_in = ST_RUN;
         ST_RUN:  if (byp_ff || ((got_l_ff || done_l) && (got_r_ff || done_r)))
                     state_in = ST_OUT;
         ST_OUT:  if (out_acc) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      left_in    = left_ff;
      right_in   = right_ff;
      if (state_ff == ST_RUN) begin
         if (byp_ff) begin
            left_in  = samp_ff;
            right_in = samp_ff;
         end else begin
            if (done_l) left_in  = sat_s(y_l);
            if (done_r) right_in = sat_s(y_r);
         end
      end
   end

   assign rsp_tdata = OW'({right_ff, left_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_ff   <= '0;
         en_ff    <= 1'b1;
         got_l_ff <= 1'b0;
         got_r_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == REG_RESONANCE) res_ff <= csr_pwdata[RES_WIDTH-1:0];
            if (csr_paddr == REG_ENABLE)    en_ff  <= csr_pwdata[0];
         end
         if (state_ff != ST_RUN) begin
            got_l_ff <= 1'b0;
            got_r_ff <= 1'b0;
         end else begin
            if (done_l) got_l_ff <= 1'b1;
            if (done_r) got_r_ff <= 1'b1;
         end
      end
      if (in_acc) begin
         samp_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         cut_ff  <= req_tdata[SAMPLE_WIDTH +: CUTOFF_WIDTH];
         byp_ff  <= !en_ff;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end

`ifndef ASSERT_OFF
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("word taken while result pending");
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      (done_l || done_r) |-> state_ff == ST_RUN) else $error("ladder finished outside run");
`endif

endmodule

FILE: tb/sv/stereo_ladder_lowpass_filter_core_test.sv
// testbench for the stereo ladder lowpass filter core: stream words in and out, csr writes
// predicts both ladders in fixed point and checks every result word; depends on sllf_pkg

module stereo_ladder_lowpass_filter_core_test;
   import sllf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = SAMPLE_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int REQ_W = ((SW + CUTOFF_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((2 * SW + 7) / 8) * 8;
   localparam longint ONE_Q = 64'sd1 <<< FB;
   localparam longint HALF_Q = 64'sd1 <<< (FB - 1);
   localparam longint TUNE_L = (64'sd8 <<< FB) / 10;
   localparam longint TUNE_R = (64'sd4 <<< FB) / 10;
   localparam longint POLY_K = (64'sd56 <<< FB) / 10;
   localparam longint CLIP_K = (64'sd166667 <<< FB) / 1000000;

   typedef struct {
      logic [SW-1:0] sample;
      logic [CUTOFF_WIDTH-1:0] cutoff;
   } word_type;

   typedef struct {
      logic [SW-1:0] left;
      logic [SW-1:0] right;
   } pair_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   stereo_ladder_lowpass_filter_core u_top (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   word_type pending_words[$];
   pair_type expected_pairs[$];
   int errors = 0;
   bit sender_hold = 0;

   // predictor state
   longint res_reg;
   bit enable_reg;
   longint left_st[5], right_st[5];

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return sat32((a * b) >>> FB);
   endfunction

   function automatic longint ladder_step(ref longint s[5], input longint x, fr, rs, tune);
      longint q, pc, f, poly, g, in0, n1, n2, n3, n4, cube;
      q = sat32(ONE_Q - fr);
      pc = sat32(fr + qmul(qmul(tune, fr), q));
      f = sat32(sat32(pc + pc) - ONE_Q);
      poly = sat32(sat32(ONE_Q - q) + qmul(qmul(POLY_K, q), q));
      g = qmul(rs, sat32(ONE_Q + qmul(qmul(HALF_Q, q), poly)));
      in0 = sat32(x - qmul(g, s[4]));
      n1 = sat32(qmul(sat32(in0 + s[0]), pc) - qmul(s[1], f));
      n2 = sat32(qmul(sat32(n1 + s[1]), pc) - qmul(s[2], f));
      n3 = sat32(qmul(sat32(n2 + s[2]), pc) - qmul(s[3], f));
      n4 = sat32(qmul(sat32(n3 + s[3]), pc) - qmul(s[4], f));
      cube = qmul(qmul(qmul(n4, n4), n4), CLIP_K);
      n4 = sat32(n4 - cube);
      s[0] = in0; s[1] = n1; s[2] = n2; s[3] = n3; s[4] = n4;
      if (n4 > (64'sd1 <<< (SW - 1)) - 1) return (64'sd1 <<< (SW - 1)) - 1;
      if (n4 < -(64'sd1 <<< (SW - 1))) return -(64'sd1 <<< (SW - 1));
      return n4;
   endfunction

   function automatic pair_type filter_word(word_type w);
      pair_type r;
      longint x, fr, rs, cut;
      x = longint'($signed(w.sample));
      if (enable_reg) begin
         cut = w.cutoff > 65536 ? 65536 : w.cutoff;
         fr = (cut <<< FB) >>> 16;
         rs = (res_reg <<< FB) >>> 14;
         r.left = ladder_step(left_st, x, fr, rs, TUNE_L);
         r.right = ladder_step(right_st, x, fr, rs, TUNE_R);
      end else begin
         r.left = w.sample;
         r.right = w.sample;
      end
      return r;
   endfunction

   // sender: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_pairs.push_back(filter_word(pending_words.pop_front()));
         end
         if (req_tvalid && !req_tready) begin
            // hold the word
         end else if (gap_left > 0 || sender_hold || pending_words.size() == 0
                      || (req_tvalid && req_tready && pending_words.size() == 0)) begin
            req_tvalid <= 0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_tvalid <= 1;
            req_tdata <= REQ_W'({pending_words[0].cutoff, pending_words[0].sample});
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: stalls on its own pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_tready <= (stall_phase % 512 < 128) ? 1'b1 : ($urandom_range(0, 2) != 0);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pairs.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               pair_type e;
               e = expected_pairs.pop_front();
               if (rsp_tdata[SW-1:0] !== e.left) begin
                  $error("left_out expected %h actual %h", e.left, rsp_tdata[SW-1:0]);
                  errors++;
               end
               if (rsp_tdata[2*SW-1:SW] !== e.right) begin
                  $error("right_out expected %h actual %h", e.right, rsp_tdata[2*SW-1:SW]);
                  errors++;
               end
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == REG_RESONANCE) res_reg = data[15:0];
      else enable_reg = data[0];
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic word_type rand_word(bit wide);
      word_type w;
      w.sample = wide ? SW'($urandom) : SW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      case ($urandom_range(0, 5))
         0: w.cutoff = CUTOFF_WIDTH'($urandom_range(65537, 131071));
         1: w.cutoff = CUTOFF_WIDTH'(65536);
         default: w.cutoff = CUTOFF_WIDTH'($urandom_range(0, 65536));
      endcase
      return w;
   endfunction

   task automatic push(int s, int c);
      word_type w;
      w.sample = SW'(s); w.cutoff = CUTOFF_WIDTH'(c);
      pending_words.push_back(w);
   endtask

   initial begin
      int phase;
      res_reg = 0; enable_reg = 1;
      foreach (left_st[i]) begin
         left_st[i] = 0; right_st[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: extremes, cutoff clamp, bypass
      push(24'h7fffff, 0); push(24'h800000, 131071); push(24'h000000, 65536);
      push(24'h7fffff, 65537); push(24'h800000, 65535); push(24'hffffff, 1);
      push(24'h100000, 32768); push(24'h7fffff, 131071); push(24'h800000, 0);
      drain();
      csr_write(REG_RESONANCE, 32'hffff);
      push(24'h7fffff, 65536); push(24'h800000, 40000); push(24'h7fffff, 20000);
      push(24'h800000, 131071); push(24'h7fffff, 100);
      drain();
      csr_write(REG_ENABLE, 0);
      push(24'h7fffff, 0); push(24'h800000, 131071); push(24'h123456, 65536);
      drain();
      csr_write(REG_ENABLE, 1);
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: csr_write(REG_RESONANCE, 0);
            1: csr_write(REG_RESONANCE, $urandom_range(0, 65535));
            2: csr_write(REG_RESONANCE, 65535);
            3: csr_write(REG_ENABLE, 0);
            4: csr_write(REG_ENABLE, 1);
            default: csr_write(REG_RESONANCE, 16384);
         endcase
         repeat (100) pending_words.push_back(rand_word($urandom_range(0, 3) == 0));
         if (phase == 2) begin
            // pause the sender until every result is back
            while (pending_words.size() > 50) @(posedge clock);
            sender_hold = 1;
            @(posedge clock);
            while (req_tvalid || expected_pairs.size() != 0) @(posedge clock);
            sender_hold = 0;
         end
         drain();
      end
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("stereo_ladder_lowpass_filter_core_test: clean");
      else
         $display("stereo_ladder_lowpass_filter_core_test: errors");
      $finish;
   end

   initial begin
      #100ms;
      $display("stereo_ladder_lowpass_filter_core_test: errors");
      $finish;
   end
endmodule
